// ----- rtl/rgba_to_terminal_palette_macros.svh -----
// Assertion macros for the RGBA to terminal palette block.
// Expects clk and rst_n in scope where used; empty bodies under SYNTHESIS.
`ifndef RGBA_TO_TERMINAL_PALETTE_MACROS_SVH
`define RGBA_TO_TERMINAL_PALETTE_MACROS_SVH

`ifndef SYNTHESIS

`define RTTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rttp: same-cycle check failed");

`define RTTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rttp: next-cycle check failed");

`else

`define RTTP_ASSERT_IMP(lbl, ante, cons)

`define RTTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/rttp_pkg.sv -----
// Shared types, constants and helper functions for the terminal palette block.
// No dependencies.
package rttp_pkg;

    typedef enum logic [2:0] {
        MODE_MONO    = 3'd0,
        MODE_EIGHT   = 3'd1,
        MODE_SIXTEEN = 3'd2,
        MODE_256     = 3'd3,
        MODE_TRUE    = 3'd4
    } mode_t;

    localparam logic [7:0] RAMP_BASE   = 8'd232;
    localparam int         RAMP_OFS    = 3;
    localparam int         RAMP_STEP   = 10;
    localparam int         RAMP_MAX    = 23;
    localparam logic [7:0] CUBE_BASE   = 8'd16;
    localparam logic [7:0] CUBE_R_MUL  = 8'd36;
    localparam logic [7:0] CUBE_G_MUL  = 8'd6;
    localparam logic [7:0] CUBE_T1     = 8'd48;
    localparam logic [7:0] CUBE_T2     = 8'd115;
    localparam logic [7:0] CUBE_T3     = 8'd155;
    localparam logic [7:0] CUBE_T4     = 8'd195;
    localparam logic [7:0] CUBE_T5     = 8'd235;
    localparam logic [7:0] GRAY_NEAR   = 8'd8;
    localparam logic [7:0] HALF_LEVEL  = 8'd128;
    localparam logic [9:0] SUM_BRIGHT  = 10'd384;
    localparam logic [7:0] ALPHA_FULL  = 8'd255;
    localparam logic [3:0] BRIGHT_ADD  = 4'd8;

    typedef struct packed {
        logic [2:0] lvl_r;
        logic [2:0] lvl_g;
        logic [2:0] lvl_b;
        logic [4:0] ramp;
        logic       near_gray;
        logic [2:0] base;
        logic       bright;
        logic       alpha_hi;
    } feat_t;

    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] lvl;
        if (v < CUBE_T1)      lvl = 3'd0;
        else if (v < CUBE_T2) lvl = 3'd1;
        else if (v < CUBE_T3) lvl = 3'd2;
        else if (v < CUBE_T4) lvl = 3'd3;
        else if (v < CUBE_T5) lvl = 3'd4;
        else                  lvl = 3'd5;
        return lvl;
    endfunction

    // (v - 3) / 10 clamped to 23, as a count of independent threshold compares
    function automatic logic [4:0] ramp_step(input logic [7:0] v);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int k = 1; k <= RAMP_MAX; k++) begin
            if (v >= 8'(RAMP_OFS + RAMP_STEP * k)) cnt = cnt + 5'd1;
        end
        return cnt;
    endfunction

    function automatic logic near_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d < GRAY_NEAR;
    endfunction

endpackage

// ----- rtl/rttp_pix_if.sv -----
// Input pixel channel: valid/ready handshake with an RGBA beat.
// No dependencies.
interface rttp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

// ----- rtl/rttp_smp_if.sv -----
// Output sample channel: valid/ready handshake with a terminal colour beat.
// No dependencies.
interface rttp_smp_if;
    logic       valid;
    logic       ready;
    logic [7:0] palette_index;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       is_truecolor;

    modport source (output valid, output palette_index, output green_out,
                    output blue_out, output alpha_out, output is_truecolor, input ready);
    modport sink   (input valid, input palette_index, input green_out,
                    input blue_out, input alpha_out, input is_truecolor, output ready);
endinterface

// ----- rtl/rttp_cfg_if.sv -----
// Configuration write channel: valid/ready handshake carrying the mode register.
// No dependencies.
interface rttp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] colour_mode;

    modport source (output valid, output colour_mode, input ready);
    modport sink   (input valid, input colour_mode, output ready);
endinterface

// ----- rtl/rttp_feat.sv -----
// Per-pixel feature extraction: cube levels, gray ramp step, near-gray and
// threshold flags. Depends on rttp_pkg.
module rttp_feat (
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic [7:0]      alpha,
    output rttp_pkg::feat_t feat
);
    import rttp_pkg::*;

    logic [9:0] sum;

    assign sum = 10'(red) + 10'(green) + 10'(blue);

    always_comb
    begin
        feat.lvl_r     = cube_level(red);
        feat.lvl_g     = cube_level(green);
        feat.lvl_b     = cube_level(blue);
        feat.ramp      = ramp_step(red);
        feat.near_gray = near_pair(red, green) && near_pair(green, blue)
                         && near_pair(red, blue);
        feat.base      = {blue >= HALF_LEVEL, green >= HALF_LEVEL, red >= HALF_LEVEL};
        feat.bright    = sum >= SUM_BRIGHT;
        feat.alpha_hi  = alpha >= HALF_LEVEL;
    end

endmodule

// ----- rtl/rgba_to_terminal_palette.sv -----
// Top level: RGBA pixel to terminal colour sample, three-stage pipeline.
// Depends on rttp_pkg, rttp_*_if, rttp_feat and the assertion macro header.
//
// Converts one RGBA pixel per clock, when the output is not stalled, into a
// terminal colour sample under the colour_mode register (0 mono, 1 eight,
// 2 sixteen, 3 256 colour, 4 truecolor; 5..7 give an all-zero sample).
// Throughput is one beat per cycle while smp.ready does not stall the output.
// An accepted beat passes three register stages (input capture, feature
// extraction, index select into the output register) before it is offered
// on smp; a low smp.ready holds it and the beats behind it. The mode is
// sampled with each beat at input accept. The config port is always ready;
// write it only while the pipeline is empty.
`include "rgba_to_terminal_palette_macros.svh"

module rgba_to_terminal_palette (
    input  logic       clk,
    input  logic       rst_n,
    rttp_cfg_if.sink   cfg,
    rttp_pix_if.sink   pix,
    rttp_smp_if.source smp
);
    import rttp_pkg::*;

    mode_t colour_mode_reg;

    logic       en1, en2, en3;

    logic       v1_reg;
    logic [7:0] r1_reg, g1_reg, b1_reg, a1_reg;
    mode_t      m1_reg;

    feat_t      feat1;
    logic       v2_reg;
    feat_t      f2_reg;
    logic [7:0] r2_reg, g2_reg, b2_reg, a2_reg;
    mode_t      m2_reg;

    logic       v3_reg;
    logic [7:0] idx3_reg, g3_reg, b3_reg, a3_reg;
    logic       tc3_reg;

    logic [7:0] idx3_next, g3_next, b3_next, a3_next;
    logic       tc3_next;
    logic [7:0] cube_idx, ramp_idx, abin;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            colour_mode_reg <= MODE_256;
        else if (cfg.valid)
            colour_mode_reg <= mode_t'(cfg.colour_mode);
    end

    assign en3       = !v3_reg || smp.ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign pix.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pix.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 1: capture
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            r1_reg <= pix.red_in;
            g1_reg <= pix.green_in;
            b1_reg <= pix.blue_in;
            a1_reg <= pix.alpha_in;
            m1_reg <= colour_mode_reg;
        end
    end

    rttp_feat u_feat (
        .red   (r1_reg),
        .green (g1_reg),
        .blue  (b1_reg),
        .alpha (a1_reg),
        .feat  (feat1)
    );

    // stage 2: features
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            f2_reg <= feat1;
            r2_reg <= r1_reg;
            g2_reg <= g1_reg;
            b2_reg <= b1_reg;
            a2_reg <= a1_reg;
            m2_reg <= m1_reg;
        end
    end

    // stage 3: index select
    assign cube_idx = CUBE_BASE + 8'(f2_reg.lvl_r) * CUBE_R_MUL
                      + 8'(f2_reg.lvl_g) * CUBE_G_MUL + 8'(f2_reg.lvl_b);
    assign ramp_idx = RAMP_BASE + 8'(f2_reg.ramp);
    assign abin     = f2_reg.alpha_hi ? ALPHA_FULL : 8'd0;

    always_comb
    begin
        idx3_next = 8'd0;
        g3_next   = 8'd0;
        b3_next   = 8'd0;
        a3_next   = 8'd0;
        tc3_next  = 1'b0;
        unique case (m2_reg)
            MODE_MONO:
            begin
                idx3_next = ramp_idx;
                a3_next   = abin;
            end
            MODE_EIGHT:
            begin
                idx3_next = 8'(f2_reg.base);
                a3_next   = abin;
            end
            MODE_SIXTEEN:
            begin
                idx3_next = 8'(f2_reg.base) + (f2_reg.bright ? 8'(BRIGHT_ADD) : 8'd0);
                a3_next   = abin;
            end
            MODE_256:
            begin
                idx3_next = f2_reg.near_gray ? ramp_idx : cube_idx;
                a3_next   = abin;
            end
            MODE_TRUE:
            begin
                idx3_next = r2_reg;
                g3_next   = g2_reg;
                b3_next   = b2_reg;
                a3_next   = a2_reg;
                tc3_next  = 1'b1;
            end
            default:
            begin
                idx3_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            idx3_reg <= idx3_next;
            g3_reg   <= g3_next;
            b3_reg   <= b3_next;
            a3_reg   <= a3_next;
            tc3_reg  <= tc3_next;
        end
    end

    assign smp.valid         = v3_reg;
    assign smp.palette_index = idx3_reg;
    assign smp.green_out     = g3_reg;
    assign smp.blue_out      = b3_reg;
    assign smp.alpha_out     = a3_reg;
    assign smp.is_truecolor  = tc3_reg;

    `RTTP_ASSERT_NEXT(a_accept_fills_s1, pix.valid && pix.ready, v1_reg)
    `RTTP_ASSERT_NEXT(a_s1_moves_to_s2, v1_reg && en2, v2_reg)
    `RTTP_ASSERT_IMP(a_palette_rgb_zero, smp.valid && !smp.is_truecolor, smp.green_out == 8'd0 && smp.blue_out == 8'd0)
    `RTTP_ASSERT_IMP(a_palette_alpha_bin, smp.valid && !smp.is_truecolor, smp.alpha_out == 8'd0 || smp.alpha_out == ALPHA_FULL)

endmodule

// ----- sim/tb.sv -----
// Testbench for rgba_to_terminal_palette: random and directed pixels in every colour mode,
// with the output samples checked against a behavioral palette predictor.
// Depends on rttp_pkg, rttp_pix_if, rttp_smp_if, rttp_cfg_if and the block itself.
module tb;
    import rttp_pkg::*;

    localparam logic [2:0] MODE_UNKNOWN = 3'd7;
    localparam int PHASE_ITEMS = 145;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [7:0] palette;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       truecolor;
    } sample_t;

    logic clk;
    logic rst_n;

    rttp_cfg_if cfg_ch ();
    rttp_pix_if pix_ch ();
    rttp_smp_if smp_ch ();

    rgba_to_terminal_palette dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pix   (pix_ch),
        .smp   (smp_ch)
    );

    pixel_t     pending_pixels[$];
    sample_t    expected_samples[$];
    logic [2:0] active_mode;
    int         mismatch_count;
    int         burst_left;
    int         gap_left;
    logic [15:0] stall_pat;
    logic [3:0]  stall_pos;
    int boundary_vals[20] = '{0, 2, 3, 12, 13, 47, 48, 114, 115, 127,
                              128, 154, 155, 194, 195, 232, 233, 234, 235, 255};

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [7:0] ramp_index(input logic [7:0] v);
        int step;
        step = (v < 3) ? 0 : (int'(v) - 3) / 10;
        if (step > 23)
            step = 23;
        return 8'(232 + step);
    endfunction

    function automatic int cube_step(input logic [7:0] v);
        if (v < 48)
            return 0;
        if (v < 115)
            return 1;
        if (v < 155)
            return 2;
        if (v < 195)
            return 3;
        if (v < 235)
            return 4;
        return 5;
    endfunction

    function automatic int gap8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic sample_t convert_pixel(input logic [2:0] mode, input pixel_t p);
        sample_t    s;
        logic [7:0] alpha_bin;
        logic [7:0] base;
        s = '0;
        alpha_bin = (p.alpha >= 128) ? 8'd255 : 8'd0;
        base = {5'd0, p.blue >= 128, p.green >= 128, p.red >= 128};
        case (mode)
            MODE_MONO:
            begin
                s.palette = ramp_index(p.red);
                s.alpha = alpha_bin;
            end
            MODE_EIGHT:
            begin
                s.palette = base;
                s.alpha = alpha_bin;
            end
            MODE_SIXTEEN:
            begin
                s.palette = base +
                    ((int'(p.red) + int'(p.green) + int'(p.blue) >= 384) ? 8'd8 : 8'd0);
                s.alpha = alpha_bin;
            end
            MODE_256:
            begin
                if (gap8(p.red, p.green) < 8 && gap8(p.green, p.blue) < 8 &&
                    gap8(p.red, p.blue) < 8)
                    s.palette = ramp_index(p.red);
                else
                    s.palette = 8'(16 + 36 * cube_step(p.red) + 6 * cube_step(p.green) +
                                   cube_step(p.blue));
                s.alpha = alpha_bin;
            end
            MODE_TRUE:
            begin
                s.palette = p.red;
                s.green = p.green;
                s.blue = p.blue;
                s.alpha = p.alpha;
                s.truecolor = 1'b1;
            end
            default:
                s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] clamp8(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] near_boundary();
        return clamp8(boundary_vals[$urandom_range(0, 19)] + int'($urandom_range(0, 2)) - 1);
    endfunction

    // mix of uniform pixels, near-gray pixels and channels sitting on the thresholds
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     v;
        p = pixel_t'($urandom);
        case ($urandom_range(0, 2))
            1:
            begin
                v = (($urandom_range(0, 3) == 0) ? boundary_vals[$urandom_range(0, 19)]
                                                 : $urandom_range(0, 255));
                p.red = clamp8(v + int'($urandom_range(0, 18)) - 9);
                p.green = clamp8(v + int'($urandom_range(0, 18)) - 9);
                p.blue = clamp8(v + int'($urandom_range(0, 18)) - 9);
            end
            2:
            begin
                p.red = near_boundary();
                p.green = near_boundary();
                p.blue = near_boundary();
                p.alpha = clamp8(128 + int'($urandom_range(0, 4)) - 2);
            end
            default:
                ;
        endcase
        return p;
    endfunction

    task automatic add_pixel(input int r, input int g, input int b, input int a);
        pending_pixels.push_back({8'(r), 8'(g), 8'(b), 8'(a)});
    endtask

    task automatic wait_idle();
        while (!(pending_pixels.size() == 0 && expected_samples.size() == 0 && !pix_ch.valid))
            @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        wait_idle();
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.colour_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        active_mode = m;
    endtask

    task automatic run_random(input logic [2:0] m, input int count);
        set_mode(m);
        repeat (count)
            pending_pixels.push_back(random_pixel());
        wait_idle();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pixel_t nxt;
        if (!rst_n)
        begin
            pix_ch.valid <= 1'b0;
            pix_ch.red_in <= 8'd0;
            pix_ch.green_in <= 8'd0;
            pix_ch.blue_in <= 8'd0;
            pix_ch.alpha_in <= 8'd0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
                expected_samples.push_back(convert_pixel(active_mode,
                    {pix_ch.red_in, pix_ch.green_in, pix_ch.blue_in, pix_ch.alpha_in}));
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix_ch.valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    nxt = pending_pixels.pop_front();
                    pix_ch.valid <= 1'b1;
                    pix_ch.red_in <= nxt.red;
                    pix_ch.green_in <= nxt.green;
                    pix_ch.blue_in <= nxt.blue;
                    pix_ch.alpha_in <= nxt.alpha;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : sample_monitor
        sample_t want;
        sample_t got;
        if (!rst_n)
        begin
            smp_ch.ready <= 1'b0;
            stall_pat = 16'h0;
            stall_pos = 4'd0;
        end
        else
        begin
            if (smp_ch.valid && smp_ch.ready)
            begin
                got = {smp_ch.palette_index, smp_ch.green_out, smp_ch.blue_out,
                       smp_ch.alpha_out, smp_ch.is_truecolor};
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected sample beat: idx=%0d g=%0d b=%0d a=%0d tc=%0d",
                                 got.palette, got.green, got.blue, got.alpha, got.truecolor);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("sample mismatch: exp idx=%0d g=%0d b=%0d a=%0d tc=%0d",
                                   want.palette, want.green, want.blue, want.alpha,
                                   want.truecolor);
                            $display(" got idx=%0d g=%0d b=%0d a=%0d tc=%0d",
                                     got.palette, got.green, got.blue, got.alpha,
                                     got.truecolor);
                        end
                    end
                end
            end
            if (stall_pos == 4'd0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
            smp_ch.ready <= !stall_pat[stall_pos];
            stall_pos = stall_pos + 4'd1;
        end
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.colour_mode = 3'd0;
        mismatch_count = 0;
        active_mode = MODE_256;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode: gray ramp ends, near-gray limit, cube thresholds
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 255);
        add_pixel(12, 12, 12, 127);
        add_pixel(13, 13, 13, 128);
        add_pixel(232, 232, 232, 200);
        add_pixel(233, 240, 236, 50);
        add_pixel(100, 107, 100, 128);
        add_pixel(100, 108, 100, 127);
        add_pixel(47, 114, 154, 255);
        add_pixel(48, 115, 155, 1);
        add_pixel(194, 234, 235, 0);
        wait_idle();

        // mono ignores green and blue
        set_mode(MODE_MONO);
        add_pixel(2, 255, 0, 128);
        add_pixel(3, 0, 255, 127);
        add_pixel(13, 170, 85, 255);
        wait_idle();

        set_mode(MODE_EIGHT);
        add_pixel(127, 128, 255, 128);
        add_pixel(128, 127, 0, 127);
        wait_idle();

        // bright bit at the channel sum limit
        set_mode(MODE_SIXTEEN);
        add_pixel(127, 128, 128, 255);
        add_pixel(128, 128, 128, 0);
        add_pixel(255, 0, 129, 128);
        wait_idle();

        set_mode(MODE_TRUE);
        add_pixel(0, 255, 170, 85);
        add_pixel(255, 0, 85, 170);
        wait_idle();

        set_mode(MODE_UNKNOWN);
        add_pixel(255, 255, 255, 255);
        wait_idle();

        run_random(MODE_MONO, PHASE_ITEMS);
        run_random(MODE_TRUE, PHASE_ITEMS);
        repeat (10)
            run_random(3'($urandom_range(0, 4)), PHASE_ITEMS);
        run_random(MODE_UNKNOWN, 10);

        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- rgba_to_terminal_palette.f -----
+incdir+rtl
rtl/rttp_pkg.sv
rtl/rttp_pix_if.sv
rtl/rttp_smp_if.sv
rtl/rttp_cfg_if.sv
rtl/rttp_feat.sv
rtl/rgba_to_terminal_palette.sv
sim/tb.sv
